/* rtl/core/acs_pkg.sv */
// ----------------------------------------------------------------------------
// acs_pkg: shared types and constants for the air compressor supervisor
// Status codes, sequencer states, register indexes and digit-serial sizing.
// ----------------------------------------------------------------------------
package acs_pkg;

	// digit-serial sizing
	localparam int DIG       = 2;
	localparam int TIME_W    = 32;
	localparam int VOLT_W    = 16;
	localparam int STEP_W    = 4;
	localparam int DIV_STEPS = 8;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TIME_W / DIG - 1);

	localparam logic [TIME_W-1:0] UNARMED = '1;

	// air threshold handling
	localparam logic [6:0] AIR_DEFAULT = 7'd80;
	localparam logic [6:0] AIR_MAX     = 7'd100;
	localparam logic [7:0] MIN_RUN     = 8'd24;

	// register indexes
	typedef enum logic [2:0] {
		REG_LOW_LIMIT  = 3'd0,
		REG_HIGH_LIMIT = 3'd1,
		REG_AIR_THR    = 3'd2,
		REG_AUTO_UPD   = 3'd3,
		REG_HOLD_TIME  = 3'd4
	} reg_idx_t;

	// result status codes
	typedef enum logic [2:0] {
		STAT_IDLE       = 3'd0,
		STAT_STARTED    = 3'd1,
		STAT_LOW_FAULT  = 3'd2,
		STAT_HIGH_FAULT = 3'd3,
		STAT_NOT_READY  = 3'd4,
		STAT_VOLT_WAIT  = 3'd5,
		STAT_BUSY       = 3'd6
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RUN,
		SQ_FIN
	} seq_t;

	// flags gathered by the serial compare/add unit
	typedef struct packed {
		logic lo_gt;    // now above low-voltage deadline
		logic hi_gt;    // now above high-voltage deadline
		logic lo_ones;  // low deadline unarmed
		logic hi_ones;  // high deadline unarmed
		logic v_lo;     // voltage below low limit
		logic v_hi;     // voltage above high limit
	} ser_flags_t;

endpackage

/* rtl/core/air_compressor_supervisor.sv */
// ----------------------------------------------------------------------------
// air_compressor_supervisor: voltage-guarded compressor start control
// One control tick in, one status word out.
//
//  channel   dir  fields (lsb first)
//  s_axis    in   now_ms[31:0] supply_voltage[15:0] air_level[7:0]
//                 engine_running valves_busy link_ok
//  m_axis    out  status[2:0] start_engine run_len[7:0]
//  cfg       in   cfg_we, cfg_addr (register index), cfg_wdata
//
// After its accept, a word's digits pass through the two-bit serial compare/add unit,
// then its result is committed to the output register.
// The input reopens the cycle after the commit, so a new word waits for the last one's commit.
// The divider runs alongside the serial unit while the step counter is below DIV_STEPS.
// Reset disarms both deadlines and loads register defaults.
// A new word is accepted while a result waits; the commit waits for m_axis.
// ----------------------------------------------------------------------------
module air_compressor_supervisor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// now_ms, supply_voltage, air_level, engine_running, valves_busy, link_ok, pad
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status, start_engine, run_len, pad
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import acs_pkg::*;

	seq_t              seq_q, seq_nx;
	logic [STEP_W-1:0] step_q;

	logic [VOLT_W-1:0] lo_lim_q, hi_lim_q, hold_q;
	logic [6:0]        thr_q;
	logic              auto_q;
	logic [TIME_W-1:0] lo_dl_q, hi_dl_q;

	logic       engine_q, busy_q, link_q, air_lt_q;
	logic       accept, load, ser_en, div_en, commit, out_free;
	ser_flags_t flags;
	logic [TIME_W-1:0] sum;
	logic [7:0] quot;

	status_t    stat_nx;
	logic [7:0] count_nx;
	logic [7:0] air_in;
	logic [6:0] thr_in;

	logic       out_valid_q;
	status_t    stat_q;
	logic       start_q;
	logic [7:0] count_q;

	assign air_in = s_axis_tdata[55:48];
	assign thr_in = cfg_wdata[6:0];

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seq_q <= SQ_IDLE;
		else seq_q <= seq_nx;
	end

	// next state and step controls
	always_comb begin
		seq_nx        = seq_q;
		s_axis_tready = 1'b0;
		ser_en        = 1'b0;
		commit        = 1'b0;
		out_free      = !out_valid_q || m_axis_tready;
		case (seq_q)
			SQ_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) seq_nx = SQ_RUN;
			end
			SQ_RUN: begin
				ser_en = 1'b1;
				if (step_q == LAST_STEP) seq_nx = SQ_FIN;
			end
			SQ_FIN: begin
				if (out_free) begin
					commit = 1'b1;
					seq_nx = SQ_IDLE;
				end
			end
			default: seq_nx = SQ_IDLE;
		endcase
		accept = s_axis_tvalid && s_axis_tready;
		load   = accept;
		div_en = ser_en && (step_q < STEP_W'(DIV_STEPS));
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= '0;
		else if (load) step_q <= '0;
		else if (ser_en) step_q <= step_q + 1'b1;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_lim_q <= '0;
			hi_lim_q <= '1;
			thr_q    <= AIR_DEFAULT;
			auto_q   <= 1'b1;
			hold_q   <= VOLT_W'(5000);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LOW_LIMIT:  lo_lim_q <= cfg_wdata;
				REG_HIGH_LIMIT: hi_lim_q <= cfg_wdata;
				REG_AIR_THR:    thr_q    <= (thr_in > AIR_MAX) ? AIR_DEFAULT : thr_in;
				REG_AUTO_UPD:   auto_q   <= cfg_wdata[0];
				REG_HOLD_TIME:  hold_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// hold the tick flags for the commit
	always_ff @(posedge clk) begin
		if (load) begin
			engine_q <= s_axis_tdata[56];
			busy_q   <= s_axis_tdata[57];
			link_q   <= s_axis_tdata[58];
			air_lt_q <= (air_in < {1'b0, thr_q});
		end
	end

	acs_serial u_serial (
		.clk    (clk),
		.load   (load),
		.en     (ser_en),
		.step   (step_q),
		.now    (s_axis_tdata[31:0]),
		.vol    (s_axis_tdata[47:32]),
		.lo_lim (lo_lim_q),
		.hi_lim (hi_lim_q),
		.hold   (hold_q),
		.lo_dl  (lo_dl_q),
		.hi_dl  (hi_dl_q),
		.flags  (flags),
		.sum    (sum)
	);

	acs_div u_div (
		.clk  (clk),
		.load (load),
		.en   (div_en),
		.air  (air_in),
		.thr  (thr_q),
		.quot (quot)
	);

	// decide the result from the gathered flags
	always_comb begin
		count_nx = 8'd0;
		if (flags.lo_gt) stat_nx = STAT_LOW_FAULT;
		else if (flags.hi_gt) stat_nx = STAT_HIGH_FAULT;
		else if (flags.v_lo || flags.v_hi) stat_nx = STAT_VOLT_WAIT;
		else if (!auto_q || !link_q) stat_nx = STAT_NOT_READY;
		else if (!air_lt_q || engine_q) stat_nx = STAT_IDLE;
		else if (busy_q) stat_nx = STAT_BUSY;
		else begin
			stat_nx  = STAT_STARTED;
			count_nx = (quot < MIN_RUN) ? MIN_RUN : quot;
		end
	end

	// update deadlines at commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_dl_q <= UNARMED;
			hi_dl_q <= UNARMED;
		end else if (commit) begin
			if (flags.lo_gt) begin
				lo_dl_q <= UNARMED;
			end else if (flags.hi_gt) begin
				hi_dl_q <= UNARMED;
			end else if (flags.v_lo) begin
				if (flags.lo_ones) lo_dl_q <= sum;
			end else begin
				lo_dl_q <= UNARMED;
				if (flags.v_hi) begin
					if (flags.hi_ones) hi_dl_q <= sum;
				end else begin
					hi_dl_q <= UNARMED;
				end
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (commit) out_valid_q <= 1'b1;
		else if (m_axis_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			stat_q  <= stat_nx;
			start_q <= (stat_nx == STAT_STARTED);
			count_q <= count_nx;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, count_q, start_q, stat_q};

endmodule

/* rtl/core/acs_serial.sv */
// ----------------------------------------------------------------------------
// acs_serial: digit-serial compare and add unit
// Walks time and voltage LSB first, two bits per cycle: deadline compares,
// unarmed checks, voltage window compares and the new deadline sum.
// ----------------------------------------------------------------------------
module acs_serial (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        en,
	input  logic [acs_pkg::STEP_W-1:0]  step,
	input  logic [acs_pkg::TIME_W-1:0]  now,
	input  logic [acs_pkg::VOLT_W-1:0]  vol,
	input  logic [acs_pkg::VOLT_W-1:0]  lo_lim,
	input  logic [acs_pkg::VOLT_W-1:0]  hi_lim,
	input  logic [acs_pkg::VOLT_W-1:0]  hold,
	input  logic [acs_pkg::TIME_W-1:0]  lo_dl,
	input  logic [acs_pkg::TIME_W-1:0]  hi_dl,
	output acs_pkg::ser_flags_t         flags,
	output logic [acs_pkg::TIME_W-1:0]  sum
);
	import acs_pkg::*;

	logic [TIME_W-1:0] now_q;
	logic [VOLT_W-1:0] vol_q;
	logic [TIME_W-1:0] sum_q;
	logic              carry_q;
	ser_flags_t        flags_q;

	logic [DIG-1:0] now_d, lo_d, hi_d, vol_d, lol_d, hil_d, hold_d;
	logic [DIG:0]   add_d;
	logic           vol_act;

	// select the digits for this step
	always_comb begin
		vol_act = (step < STEP_W'(VOLT_W / DIG));
		now_d   = now_q[DIG-1:0];
		vol_d   = vol_q[DIG-1:0];
		lo_d    = lo_dl[step*DIG +: DIG];
		hi_d    = hi_dl[step*DIG +: DIG];
		lol_d   = lo_lim[step[STEP_W-2:0]*DIG +: DIG];
		hil_d   = hi_lim[step[STEP_W-2:0]*DIG +: DIG];
		hold_d  = vol_act ? hold[step[STEP_W-2:0]*DIG +: DIG] : '0;
		add_d   = {1'b0, now_d} + {1'b0, hold_d} + {{DIG{1'b0}}, carry_q};
	end

	// load operands, then shift one digit per step
	always_ff @(posedge clk) begin
		if (load) begin
			now_q           <= now;
			vol_q           <= vol;
			carry_q         <= 1'b0;
			flags_q.lo_gt   <= 1'b0;
			flags_q.hi_gt   <= 1'b0;
			flags_q.lo_ones <= 1'b1;
			flags_q.hi_ones <= 1'b1;
			flags_q.v_lo    <= 1'b0;
			flags_q.v_hi    <= 1'b0;
		end else if (en) begin
			now_q   <= {{DIG{1'b0}}, now_q[TIME_W-1:DIG]};
			vol_q   <= {{DIG{1'b0}}, vol_q[VOLT_W-1:DIG]};
			sum_q   <= {add_d[DIG-1:0], sum_q[TIME_W-1:DIG]};
			carry_q <= add_d[DIG];
			// higher digits override lower ones
			if (now_d > lo_d) flags_q.lo_gt <= 1'b1;
			else if (now_d < lo_d) flags_q.lo_gt <= 1'b0;
			if (now_d > hi_d) flags_q.hi_gt <= 1'b1;
			else if (now_d < hi_d) flags_q.hi_gt <= 1'b0;
			flags_q.lo_ones <= flags_q.lo_ones & (&lo_d);
			flags_q.hi_ones <= flags_q.hi_ones & (&hi_d);
			if (vol_act) begin
				if (vol_d < lol_d) flags_q.v_lo <= 1'b1;
				else if (vol_d > lol_d) flags_q.v_lo <= 1'b0;
				if (vol_d > hil_d) flags_q.v_hi <= 1'b1;
				else if (vol_d < hil_d) flags_q.v_hi <= 1'b0;
			end
		end
	end

	assign flags = flags_q;
	assign sum   = sum_q;

endmodule

/* rtl/core/acs_div.sv */
// ----------------------------------------------------------------------------
// acs_div: bit-serial run count divider
// Restoring division of (threshold - air) * 255 by threshold, one quotient
// bit per cycle while en is high.
// ----------------------------------------------------------------------------
module acs_div (
	input  logic       clk,
	input  logic       load,
	input  logic       en,
	input  logic [7:0] air,
	input  logic [6:0] thr,
	output logic [7:0] quot
);
	import acs_pkg::*;

	logic [6:0]  rem_q;
	logic [7:0]  low_q;
	logic [7:0]  quot_q;
	logic [6:0]  diff;
	logic [14:0] num;
	logic [7:0]  trial;
	logic        fits;

	// numerator and trial subtraction
	always_comb begin
		diff  = thr - air[6:0];
		num   = {diff, 8'd0} - {8'd0, diff};
		trial = {rem_q, low_q[7]};
		fits  = (trial >= {1'b0, thr});
	end

	// high bits start as the remainder since the quotient fits in a byte
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= num[14:8];
			low_q <= num[7:0];
		end else if (en) begin
			rem_q  <= fits ? 7'(trial - {1'b0, thr}) : trial[6:0];
			low_q  <= {low_q[6:0], 1'b0};
			quot_q <= {quot_q[6:0], fits};
		end
	end

	assign quot = quot_q;

endmodule

/* dv/tb_air_compressor_supervisor.sv */
// ----------------------------------------------------------------------------
// tb_air_compressor_supervisor: self-checking bench for the compressor supervisor
// Drives control ticks on s_axis and predicts each status word on m_axis, from the
// directed table or from an in-bench model of the voltage deadlines and the start
// decision. A short table of directed ticks and register writes comes first, then
// random phases under several register settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_air_compressor_supervisor;
	import acs_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int          PHASE_TICKS  = 110;
	localparam int          SETTLE_CYCLES = 40;

	// tick flag combinations for the directed table: {link_ok, valves_busy, engine_running}
	localparam logic [2:0] F_NONE   = 3'b000;
	localparam logic [2:0] F_ENGINE = 3'b001;
	localparam logic [2:0] F_VALVES = 3'b010;
	localparam logic [2:0] F_LINK   = 3'b100;

	typedef struct {
		logic [31:0] now_ms;
		logic [15:0] volt;
		logic [7:0]  air;
		logic        engine;
		logic        valves;
		logic        link;
	} tick_t;

	typedef struct {
		status_t    status;
		logic       start;
		logic [7:0] count;
	} verdict_t;

	typedef enum {ROW_TICK, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [15:0] value;
		tick_t       tick;
		bit          typed;
		verdict_t    want;
	} step_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// now_ms, supply_voltage, air_level, engine_running, valves_busy, link_ok, pad
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// status, start_engine, run_len, pad
	logic [15:0] m_axis_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [15:0] cfg_wdata;

	// supervisor copy: registers and deadlines
	logic [15:0] lim_low;
	logic [15:0] lim_high;
	logic [6:0]  air_thr;
	logic        auto_on;
	logic [15:0] hold_ms;
	logic [31:0] low_deadline;
	logic [31:0] high_deadline;

	verdict_t    pending_verdicts[$];
	step_row_t   dir_rows[$];
	int          mismatches;
	int          ticks_sent;
	int          starts_seen;
	int          faults_seen;
	int          reg_writes;
	bit          src_calm;
	bit          sink_calm;
	int          sink_stall;
	int unsigned cycle_count;

	air_compressor_supervisor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycle_count,
				pending_verdicts.size());
			$display("air_compressor_supervisor test failed");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Work out the status word for one tick and advance the deadlines
	function automatic verdict_t supervise_tick(input tick_t t);
		verdict_t    v;
		int unsigned run;
		v.status = STAT_IDLE;
		v.start  = 1'b0;
		v.count  = 8'd0;
		if (t.now_ms > low_deadline) begin
			low_deadline = UNARMED;
			v.status = STAT_LOW_FAULT;
			return v;
		end
		if (t.now_ms > high_deadline) begin
			high_deadline = UNARMED;
			v.status = STAT_HIGH_FAULT;
			return v;
		end
		if (t.volt < lim_low) begin
			if (low_deadline == UNARMED)
				low_deadline = t.now_ms + 32'(hold_ms);
			v.status = STAT_VOLT_WAIT;
			return v;
		end
		low_deadline = UNARMED;
		if (t.volt > lim_high) begin
			if (high_deadline == UNARMED)
				high_deadline = t.now_ms + 32'(hold_ms);
			v.status = STAT_VOLT_WAIT;
			return v;
		end
		high_deadline = UNARMED;
		if (!auto_on || !t.link) begin
			v.status = STAT_NOT_READY;
			return v;
		end
		if (t.air >= 8'(air_thr) || t.engine)
			return v;
		// air below a nonzero threshold, so the run fits in eight bits
		run = ((32'(air_thr) - 32'(t.air)) * 255) / 32'(air_thr);
		if (run < 32'(MIN_RUN))
			run = 32'(MIN_RUN);
		if (t.valves) begin
			v.status = STAT_BUSY;
			return v;
		end
		v.status = STAT_STARTED;
		v.start  = 1'b1;
		v.count  = run[7:0];
		return v;
	endfunction

	function automatic step_row_t tick_row(input logic [31:0] now, input logic [15:0] volt,
		input logic [7:0] air, input logic [2:0] flags, input bit typed, input status_t st,
		input logic [7:0] cnt);
		step_row_t row;
		row.kind        = ROW_TICK;
		row.idx         = REG_LOW_LIMIT;
		row.value       = 16'd0;
		row.tick.now_ms = now;
		row.tick.volt   = volt;
		row.tick.air    = air;
		row.tick.engine = flags[0];
		row.tick.valves = flags[1];
		row.tick.link   = flags[2];
		row.typed       = typed;
		row.want.status = st;
		row.want.start  = (st == STAT_STARTED);
		row.want.count  = cnt;
		return row;
	endfunction

	function automatic step_row_t reg_row(input reg_idx_t idx, input logic [15:0] value);
		step_row_t row;
		row = tick_row(32'd0, 16'd0, 8'd0, F_NONE, 1'b0, STAT_IDLE, 8'd0);
		row.kind  = ROW_REG;
		row.idx   = idx;
		row.value = value;
		return row;
	endfunction

	// Offer one word, wait for the handshake, queue its expected status
	task automatic send_tick(input tick_t t, input bit typed, input verdict_t want);
		int       gap;
		int       r;
		verdict_t got;
		gap = 0;
		if (!src_calm) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				gap = 0;
			else if (r < 85)
				gap = $urandom_range(1, 3);
			else if (r < 97)
				gap = $urandom_range(4, 10);
			else
				gap = $urandom_range(20, 60);
		end
		if ($urandom_range(0, 63) == 0)
			src_calm = !src_calm;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'd0, t.link, t.valves, t.engine, t.air, t.volt, t.now_ms};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		got = supervise_tick(t);
		pending_verdicts.push_back(typed ? want : got);
		ticks_sent++;
		if (got.status == STAT_STARTED)
			starts_seen++;
		if (got.status == STAT_LOW_FAULT || got.status == STAT_HIGH_FAULT)
			faults_seen++;
	endtask

	// Stop offering words and wait for every expected status word
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// Write one register while the block is idle and mirror it
	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_writes++;
		case (idx)
			REG_LOW_LIMIT: begin
				lim_low = value;
			end
			REG_HIGH_LIMIT: begin
				lim_high = value;
			end
			REG_AIR_THR: begin
				air_thr = (value[6:0] > AIR_MAX) ? AIR_DEFAULT : value[6:0];
			end
			REG_AUTO_UPD: begin
				auto_on = value[0];
			end
			REG_HOLD_TIME: begin
				hold_ms = value;
			end
			default: begin
			end
		endcase
	endtask

	task automatic load_setting(input logic [15:0] low, input logic [15:0] high,
		input logic [15:0] thr, input logic [15:0] auto_upd, input logic [15:0] hold);
		drain();
		write_reg(REG_LOW_LIMIT, low);
		write_reg(REG_HIGH_LIMIT, high);
		write_reg(REG_AIR_THR, thr);
		write_reg(REG_AUTO_UPD, auto_upd);
		write_reg(REG_HOLD_TIME, hold);
	endtask

	// Drive ready with stalls and check each status word against the oldest expectation
	always @(posedge clk) begin : result_sink
		verdict_t want;
		status_t  got_status;
		logic     got_start;
		logic [7:0] got_count;
		int       r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_status = status_t'(m_axis_tdata[2:0]);
			got_start  = m_axis_tdata[3];
			got_count  = m_axis_tdata[11:4];
			if (pending_verdicts.size() == 0) begin
				flag_mismatch($sformatf("status word %h with nothing expected", m_axis_tdata));
			end else begin
				want = pending_verdicts.pop_front();
				if (got_status !== want.status)
					flag_mismatch($sformatf("status %0d, expected %0d", got_status,
						want.status));
				if (got_start !== want.start)
					flag_mismatch($sformatf("start_engine %b, expected %b", got_start,
						want.start));
				if (got_count !== want.count)
					flag_mismatch($sformatf("run_len %0d, expected %0d", got_count,
						want.count));
			end
		end
		if (sink_stall > 0) begin
			m_axis_tready <= 1'b0;
			sink_stall--;
		end else begin
			m_axis_tready <= 1'b1;
			r = $urandom_range(0, 99);
			if (!sink_calm) begin
				if (r < 20)
					sink_stall = $urandom_range(1, 3);
				else if (r < 24)
					sink_stall = $urandom_range(8, 40);
			end
		end
		if ($urandom_range(0, 199) == 0)
			sink_calm = !sink_calm;
	end

	initial begin
		tick_t       t;
		verdict_t    none;
		step_row_t   row;
		logic [31:0] clock_ms;
		int          zone;
		int          r;

		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 64'd0;
		cfg_we        <= 1'b0;
		cfg_addr      <= REG_LOW_LIMIT;
		cfg_wdata     <= 16'd0;
		arst_n        <= 1'b0;

		// register defaults and unarmed deadlines
		lim_low       = 16'd0;
		lim_high      = 16'hFFFF;
		air_thr       = AIR_DEFAULT;
		auto_on       = 1'b1;
		hold_ms       = 16'd5000;
		low_deadline  = UNARMED;
		high_deadline = UNARMED;
		none          = '{STAT_IDLE, 1'b0, 8'd0};
		zone          = 0;

		// defaults: start decision, run length and its floor
		dir_rows.push_back(tick_row(32'd0, 16'd0, 8'd0, F_LINK, 1'b1, STAT_STARTED, 8'd255));
		dir_rows.push_back(tick_row(32'd1, 16'hFFFF, 8'hFF, F_LINK | F_VALVES | F_ENGINE, 1'b1,
			STAT_IDLE, 8'd0));
		dir_rows.push_back(tick_row(32'd2, 16'd30000, 8'd10, F_NONE, 1'b1, STAT_NOT_READY,
			8'd0));
		dir_rows.push_back(tick_row(32'd3, 16'd30000, 8'd10, F_LINK | F_VALVES, 1'b1, STAT_BUSY,
			8'd0));
		dir_rows.push_back(tick_row(32'd4, 16'd30000, 8'd10, F_LINK | F_ENGINE, 1'b1, STAT_IDLE,
			8'd0));
		dir_rows.push_back(tick_row(32'd5, 16'd30000, 8'd79, F_LINK, 1'b1, STAT_STARTED,
			8'd24));
		dir_rows.push_back(tick_row(32'd6, 16'd30000, 8'd80, F_LINK, 1'b1, STAT_IDLE, 8'd0));
		dir_rows.push_back(tick_row(32'hFFFF_FFFF, 16'd12345, 8'd40, F_LINK, 1'b0, STAT_IDLE,
			8'd0));
		// low deadline: arm, hold, expire, re-arm, disarm
		dir_rows.push_back(reg_row(REG_LOW_LIMIT, 16'd1000));
		dir_rows.push_back(reg_row(REG_HOLD_TIME, 16'd10));
		dir_rows.push_back(tick_row(32'd100, 16'd500, 8'd20, F_LINK, 1'b1, STAT_VOLT_WAIT,
			8'd0));
		dir_rows.push_back(tick_row(32'd105, 16'd500, 8'd20, F_LINK, 1'b1, STAT_VOLT_WAIT,
			8'd0));
		dir_rows.push_back(tick_row(32'd111, 16'd500, 8'd20, F_LINK, 1'b1, STAT_LOW_FAULT,
			8'd0));
		dir_rows.push_back(tick_row(32'd112, 16'd500, 8'd20, F_LINK, 1'b1, STAT_VOLT_WAIT,
			8'd0));
		dir_rows.push_back(tick_row(32'd113, 16'd2000, 8'd20, F_LINK, 1'b0, STAT_IDLE, 8'd0));
		// high deadline expires while the voltage has already dropped low
		dir_rows.push_back(reg_row(REG_HIGH_LIMIT, 16'd3000));
		dir_rows.push_back(tick_row(32'd200, 16'd4000, 8'd20, F_LINK, 1'b1, STAT_VOLT_WAIT,
			8'd0));
		dir_rows.push_back(tick_row(32'd211, 16'd500, 8'd20, F_LINK, 1'b1, STAT_HIGH_FAULT,
			8'd0));
		dir_rows.push_back(tick_row(32'd212, 16'd2000, 8'd90, F_LINK, 1'b0, STAT_IDLE, 8'd0));
		// deadline sums near the wrap of the millisecond clock
		dir_rows.push_back(tick_row(32'hFFFF_FFFA, 16'd500, 8'd20, F_LINK, 1'b1,
			STAT_VOLT_WAIT, 8'd0));
		dir_rows.push_back(tick_row(32'hFFFF_FFFB, 16'd500, 8'd20, F_LINK, 1'b1,
			STAT_LOW_FAULT, 8'd0));
		dir_rows.push_back(tick_row(32'hFFFF_FFF5, 16'd500, 8'd20, F_LINK, 1'b1,
			STAT_VOLT_WAIT, 8'd0));
		dir_rows.push_back(tick_row(32'hFFFF_FFFF, 16'd500, 8'd20, F_LINK, 1'b1,
			STAT_VOLT_WAIT, 8'd0));
		dir_rows.push_back(tick_row(32'd10, 16'd500, 8'd20, F_LINK, 1'b1, STAT_LOW_FAULT,
			8'd0));
		// threshold above the maximum falls back to the default, zero never runs
		dir_rows.push_back(reg_row(REG_AIR_THR, 16'd127));
		dir_rows.push_back(tick_row(32'd300, 16'd2000, 8'd79, F_LINK, 1'b1, STAT_STARTED,
			8'd24));
		dir_rows.push_back(reg_row(REG_AIR_THR, 16'd0));
		dir_rows.push_back(tick_row(32'd301, 16'd2000, 8'd0, F_LINK, 1'b1, STAT_IDLE, 8'd0));
		dir_rows.push_back(reg_row(REG_AUTO_UPD, 16'd0));
		dir_rows.push_back(tick_row(32'd302, 16'd2000, 8'd0, F_LINK, 1'b1, STAT_NOT_READY,
			8'd0));
		dir_rows.push_back(reg_row(REG_AUTO_UPD, 16'd1));
		dir_rows.push_back(reg_row(REG_AIR_THR, 16'd100));
		dir_rows.push_back(tick_row(32'd303, 16'd2000, 8'd0, F_LINK, 1'b1, STAT_STARTED,
			8'd255));
		dir_rows.push_back(tick_row(32'd304, 16'd2000, 8'd99, F_LINK, 1'b1, STAT_STARTED,
			8'd24));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_REG) begin
				drain();
				write_reg(row.idx, row.value);
			end else begin
				send_tick(row.tick, row.typed, row.want);
			end
		end

		// Random phases, one register setting each
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin
					load_setting(16'd1000, 16'd60000, 16'd100, 16'd1, 16'd20);
				end
				1: begin
					load_setting(16'hFFFF, 16'd0, 16'd127, 16'd0, 16'd0);
				end
				2: begin
					load_setting(16'd0, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF);
				end
				3: begin
					load_setting(16'd20000, 16'd40000, 16'd0, 16'd1, 16'd3);
				end
				default: begin
					load_setting(16'($urandom_range(0, 30000)), 16'($urandom_range(20000, 65535)),
						16'($urandom_range(0, 127)), 16'($urandom_range(0, 1)),
						16'($urandom_range(0, 200)));
				end
			endcase
			clock_ms = (p == 3) ? 32'hFFFF_FF00 : $urandom;
			for (int n = 0; n < PHASE_TICKS; n++) begin
				// advance time, with rare jumps and visits near the wrap
				r = $urandom_range(0, 99);
				if (r < 4)
					clock_ms = $urandom;
				else if (r < 7)
					clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
				else
					clock_ms = clock_ms + $urandom_range(0, 32'(hold_ms) / 4 + 4);
				t.now_ms = clock_ms;
				// hold the voltage in one zone for a run of ticks
				if ($urandom_range(0, 99) < 12) begin
					r = $urandom_range(0, 99);
					zone = (r < 50) ? 0 : (r < 75) ? 1 : 2;
				end
				if ($urandom_range(0, 99) < 8)
					t.volt = 16'($urandom);
				else if (zone == 1 && lim_low != 16'd0)
					t.volt = 16'($urandom_range(32'(lim_low) - 1, 0));
				else if (zone == 2 && lim_high != 16'hFFFF)
					t.volt = 16'($urandom_range(65535, 32'(lim_high) + 1));
				else if (zone == 0 && lim_low <= lim_high)
					t.volt = 16'($urandom_range(32'(lim_high), 32'(lim_low)));
				else
					t.volt = 16'($urandom);
				if (air_thr != 7'd0 && $urandom_range(0, 99) < 60)
					t.air = 8'($urandom_range(32'(air_thr) - 1, 0));
				else
					t.air = 8'($urandom);
				t.engine = ($urandom_range(0, 99) < 20);
				t.valves = ($urandom_range(0, 99) < 25);
				t.link   = ($urandom_range(0, 99) < 90);
				send_tick(t, 1'b0, none);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d ticks with %0d starts and %0d voltage faults", ticks_sent,
			starts_seen, faults_seen);
		$display("across %0d register writes, %0d mismatches", reg_writes, mismatches);
		if (mismatches == 0) begin
			$display("air_compressor_supervisor test passed");
		end else begin
			$display("air_compressor_supervisor test failed");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/acs_pkg.sv
rtl/core/acs_serial.sv
rtl/core/acs_div.sv
rtl/core/air_compressor_supervisor.sv
dv/tb_air_compressor_supervisor.sv
